### hw/rtl/v3alu_pkg.sv
// Shared widths, opcodes, pipeline payload types and saturation helper for the vector ALU.
package v3alu_pkg;

   localparam int WORD_W            = 32;
   localparam int DEFAULT_FRAC_BITS = 16;
   localparam int FUNC_W            = 4;
   localparam int LANES             = 3;
   localparam int PROD_W            = 2 * WORD_W;
   localparam int SAT_W             = PROD_W + 2;
   localparam int RAD_W             = PROD_W;
   localparam int ROOT_W            = WORD_W;
   localparam int REQ_W             = 232;
   localparam int RSP_W             = 136;
   localparam int MATCH_BIT         = 4 * WORD_W;
   localparam int DZ_BIT            = MATCH_BIT + 1;
   localparam int OVF_BIT           = MATCH_BIT + 2;

   localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD   = 4'd0,
      FUNC_SUB   = 4'd1,
      FUNC_DOT   = 4'd2,
      FUNC_CROSS = 4'd3,
      FUNC_MUL   = 4'd4,
      FUNC_DIV   = 4'd5,
      FUNC_MAG   = 4'd6,
      FUNC_NORM  = 4'd7,
      FUNC_EQUAL = 4'd8
   } func_type;

   typedef struct packed {
      logic              ovf;
      logic [WORD_W-1:0] word;
   } sat_type;

   typedef struct packed {
      func_type          func;
      logic              match;
      logic              s_neg;
      logic              s_zero;
      logic [WORD_W-1:0] s_mag;
   } ctl_type;

   typedef struct packed {
      func_type                      func;
      logic                          match;
      logic                          ovf;
      logic                          dz;
      logic                          s_neg;
      logic                          s_zero;
      logic [WORD_W-1:0]             s_mag;
      logic [LANES-1:0]              neg;
      logic [WORD_W-1:0]             scal;
      logic [LANES-1:0][WORD_W-1:0]  vec;
      logic [LANES-1:0][WORD_W-1:0]  num;
   } pay_type;

   function automatic sat_type sat_word(input logic [SAT_W-1:0] v);
      sat_type                 r;
      logic [SAT_W-WORD_W:0]   hi;
      hi = v[SAT_W-1:WORD_W-1];
      if ((hi == '0) || (hi == '1)) begin
         r.ovf  = 1'b0;
         r.word = v[WORD_W-1:0];
      end else begin
         r.ovf  = 1'b1;
         r.word = v[SAT_W-1] ? WORD_MIN : WORD_MAX;
      end
      return r;
   endfunction

endpackage

### hw/rtl/v3alu_lane.sv
// One component lane: products, floor, saturate, cross difference and squaring.
module v3alu_lane #(
   parameter int FRAC_BITS = v3alu_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                                   clock,
   input  logic                                   en,
   input  v3alu_pkg::func_type                    func,
   input  logic signed [v3alu_pkg::WORD_W-1:0]    m1a,
   input  logic signed [v3alu_pkg::WORD_W-1:0]    m1b,
   input  logic signed [v3alu_pkg::WORD_W-1:0]    m2a,
   input  logic signed [v3alu_pkg::WORD_W-1:0]    m2b,
   input  logic signed [v3alu_pkg::WORD_W-1:0]    a,
   input  logic signed [v3alu_pkg::WORD_W-1:0]    b,
   output logic [v3alu_pkg::WORD_W-1:0]           vec,
   output logic [v3alu_pkg::WORD_W-1:0]           num,
   output logic [v3alu_pkg::PROD_W-1:0]           sq,
   output logic signed [v3alu_pkg::PROD_W-1:0]    prod,
   output logic                                   ovf
);

   localparam int WORD_W = v3alu_pkg::WORD_W;
   localparam int PROD_W = v3alu_pkg::PROD_W;
   localparam int SAT_W  = v3alu_pkg::SAT_W;

   logic signed [PROD_W-1:0] p1_ff, p2_ff;
   logic signed [WORD_W-1:0] a1_ff, b1_ff;
   v3alu_pkg::func_type      func1_ff;

   logic signed [PROD_W-1:0] h1, h2;
   v3alu_pkg::sat_type       add_s, sub_s, mul_s, crs_s;
   logic [WORD_W-1:0]        vec2_in, v2_in;
   logic                     ovf2_in;

   logic [WORD_W-1:0]        vec2_ff;
   logic signed [WORD_W-1:0] v2_ff;
   logic signed [PROD_W-1:0] prod2_ff;
   logic                     ovf2_ff;

   logic [WORD_W-1:0]        vec3_ff, num3_ff;
   logic [PROD_W-1:0]        sq3_ff;
   logic signed [PROD_W-1:0] prod3_ff;
   logic                     ovf3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff    <= PROD_W'(m1a) * PROD_W'(m1b);
         p2_ff    <= PROD_W'(m2a) * PROD_W'(m2b);
         a1_ff    <= a;
         b1_ff    <= b;
         func1_ff <= func;
      end
   end

   always_comb begin
      h1    = p1_ff >>> FRAC_BITS;
      h2    = p2_ff >>> FRAC_BITS;
      add_s = v3alu_pkg::sat_word(SAT_W'(a1_ff) + SAT_W'(b1_ff));
      sub_s = v3alu_pkg::sat_word(SAT_W'(a1_ff) - SAT_W'(b1_ff));
      mul_s = v3alu_pkg::sat_word(SAT_W'(h1));
      crs_s = v3alu_pkg::sat_word(SAT_W'(h1) - SAT_W'(h2));
      vec2_in = '0;
      v2_in   = a1_ff;
      ovf2_in = 1'b0;
      case (func1_ff)
         v3alu_pkg::FUNC_ADD: begin
            vec2_in = add_s.word;
            ovf2_in = add_s.ovf;
         end
         v3alu_pkg::FUNC_SUB: begin
            vec2_in = sub_s.word;
            ovf2_in = sub_s.ovf;
         end
         v3alu_pkg::FUNC_MUL: begin
            vec2_in = mul_s.word;
            ovf2_in = mul_s.ovf;
         end
         v3alu_pkg::FUNC_CROSS: begin
            v2_in   = crs_s.word;
            ovf2_in = crs_s.ovf;
         end
         default: begin
            vec2_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec2_ff  <= vec2_in;
         v2_ff    <= v2_in;
         prod2_ff <= p1_ff;
         ovf2_ff  <= ovf2_in;
         vec3_ff  <= vec2_ff;
         num3_ff  <= v2_ff;
         sq3_ff   <= PROD_W'(v2_ff) * PROD_W'(v2_ff);
         prod3_ff <= prod2_ff;
         ovf3_ff  <= ovf2_ff;
      end
   end

   assign vec  = vec3_ff;
   assign num  = num3_ff;
   assign sq   = sq3_ff;
   assign prod = prod3_ff;
   assign ovf  = ovf3_ff;

endmodule

### hw/rtl/v3alu_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module v3alu_sqrt (
   input  logic                           clock,
   input  logic                           en,
   input  logic [v3alu_pkg::RAD_W-1:0]    radicand,
   output logic [v3alu_pkg::ROOT_W-1:0]   root
);

   localparam int RAD_W  = v3alu_pkg::RAD_W;
   localparam int ROOT_W = v3alu_pkg::ROOT_W;
   localparam int REM_W  = ROOT_W + 3;

   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [REM_W-1:0]  rem_prev, rem_sh, trial, rem_in;
      logic [ROOT_W-1:0] root_prev, root_in;
      logic [RAD_W-1:0]  rad_prev, rad_in;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = radicand;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1 -: 2]};
         trial  = REM_W'({root_prev, 2'b01});
         rad_in = {rad_prev[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_prev[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= rad_in;
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

### hw/rtl/v3alu_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module v3alu_div #(
   parameter int NUM_W = v3alu_pkg::WORD_W + v3alu_pkg::DEFAULT_FRAC_BITS,
   parameter int DEN_W = v3alu_pkg::WORD_W
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quo
);

   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0] nq_ff  [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [DEN_W-1:0] rem_prev, den_prev, rem_in;
      logic [NUM_W-1:0] nq_prev, nq_in;
      logic [DEN_W:0]   rem_sh, diff;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign nq_prev  = num;
         assign den_prev = den;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign nq_prev  = nq_ff[k-1];
         assign den_prev = den_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_prev, nq_prev[NUM_W-1]};
         diff   = rem_sh - {1'b0, den_prev};
         if (rem_sh >= {1'b0, den_prev}) begin
            rem_in = diff[DEN_W-1:0];
            nq_in  = {nq_prev[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DEN_W-1:0];
            nq_in  = {nq_prev[NUM_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            nq_ff[k]  <= nq_in;
            den_ff[k] <= den_prev;
         end
      end
   end

   assign quo = nq_ff[NUM_W-1];

endmodule

### hw/rtl/vector3_fixed_point_alu.sv
// Top level of the three-lane fixed-point vector ALU with merge, root, divide and output stages.
//
// Requests enter on the req_ channel (tvalid/tready/tdata), one per cycle when
// req_tready is high; each request carries an opcode, vectors a and b and a scalar.
// Results leave on the rsp_ channel, one per request, in request order.
// Every opcode passes through the same stages from acceptance to rsp_tvalid.
// Three component lanes form products, floors and squares; a merge stage sums the
// dot product and the squares; a 32-stage pipelined root follows, then three
// pipelined dividers of 32 + FRAC_BITS stages, one per component.
// The output register is backed by one skid entry: when the receiver stalls as a
// new result arrives, the result goes to the skid entry and req_tready drops in the
// next cycle, freezing the pipeline until the receiver takes a result.
// Reset (synchronous, active high) empties the pipeline and both output entries.
module vector3_fixed_point_alu #(
   parameter int FRAC_BITS = v3alu_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // func[3:0], a_x, a_y, a_z, b_x, b_y, b_z, scalar (32 bits each), zero fill
   input  logic [v3alu_pkg::REQ_W-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // res_x, res_y, res_z, res_scalar (32 bits each), match, div_zero, overflow, zero fill
   output logic [v3alu_pkg::RSP_W-1:0]   rsp_tdata
);

   localparam int WORD_W    = v3alu_pkg::WORD_W;
   localparam int FUNC_W    = v3alu_pkg::FUNC_W;
   localparam int LANES     = v3alu_pkg::LANES;
   localparam int PROD_W    = v3alu_pkg::PROD_W;
   localparam int SAT_W     = v3alu_pkg::SAT_W;
   localparam int RAD_W     = v3alu_pkg::RAD_W;
   localparam int ROOT_W    = v3alu_pkg::ROOT_W;
   localparam int RSP_W     = v3alu_pkg::RSP_W;
   localparam int NUM_W     = WORD_W + FRAC_BITS;
   localparam int FRONT_LAT = 3;
   localparam int SQ_LAT    = ROOT_W;
   localparam int DIV_LAT   = NUM_W;

   logic                      en, accept;
   v3alu_pkg::func_type       req_func;
   logic signed [WORD_W-1:0]  a [LANES];
   logic signed [WORD_W-1:0]  b [LANES];
   logic signed [WORD_W-1:0]  s;
   v3alu_pkg::ctl_type        ctl_in;

   logic [FRONT_LAT-1:0]      vld_f_ff;
   v3alu_pkg::ctl_type        ctl_ff [FRONT_LAT];

   logic [WORD_W-1:0]         ln_vec  [LANES];
   logic [WORD_W-1:0]         ln_num  [LANES];
   logic [PROD_W-1:0]         ln_sq   [LANES];
   logic signed [PROD_W-1:0]  ln_prod [LANES];
   logic [LANES-1:0]          ln_ovf;

   logic signed [SAT_W-1:0]   dot_sum, dot_sh;
   v3alu_pkg::sat_type        dot_s;
   v3alu_pkg::pay_type        pay4_in, pay4_ff;
   logic [RAD_W-1:0]          magsum_in, magsum_ff;
   logic                      vld4_ff;

   logic [SQ_LAT-1:0]         vld_s_ff;
   v3alu_pkg::pay_type        pay_s_ff [SQ_LAT];
   logic [ROOT_W-1:0]         mag;

   v3alu_pkg::pay_type        pay5_in, pay5_ff;
   logic [WORD_W-1:0]         nmag_in [LANES];
   logic [WORD_W-1:0]         nmag_ff [LANES];
   logic [WORD_W-1:0]         den_in, den_ff;
   logic                      vld5_ff;

   logic [DIV_LAT-1:0]        vld_d_ff;
   v3alu_pkg::pay_type        pay_d_ff [DIV_LAT];
   logic [NUM_W-1:0]          quo [LANES];

   v3alu_pkg::pay_type        pl_out;
   logic signed [SAT_W-1:0]   qv [LANES];
   v3alu_pkg::sat_type        qs [LANES];
   logic [WORD_W-1:0]         res [LANES];
   logic                      quot_op, ovf_out, push;
   logic [RSP_W-1:0]          rsp_in;

   logic                      out_vld_ff, skid_vld_ff;
   logic [RSP_W-1:0]          out_ff, skid_ff;

   assign en         = !skid_vld_ff;
   assign req_tready = en;
   assign accept     = req_tvalid && en;
   assign req_func   = v3alu_pkg::func_type'(req_tdata[FUNC_W-1:0]);
   assign s          = req_tdata[FUNC_W + WORD_W*2*LANES +: WORD_W];

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         a[i] = req_tdata[FUNC_W + WORD_W*i +: WORD_W];
         b[i] = req_tdata[FUNC_W + WORD_W*(LANES+i) +: WORD_W];
      end
      ctl_in.func   = req_func;
      ctl_in.match  = (req_func == v3alu_pkg::FUNC_EQUAL) &&
                      (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
      ctl_in.s_neg  = s[WORD_W-1];
      ctl_in.s_zero = (s == '0);
      ctl_in.s_mag  = s[WORD_W-1] ? (~s + 1'b1) : s;
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      localparam int J = (i + 1) % LANES;
      localparam int K = (i + 2) % LANES;
      logic signed [WORD_W-1:0] m1a, m1b;

      always_comb begin
         m1a = a[i];
         m1b = b[i];
         case (req_func)
            v3alu_pkg::FUNC_CROSS: begin
               m1a = a[J];
               m1b = b[K];
            end
            v3alu_pkg::FUNC_MUL: begin
               m1b = s;
            end
            default: begin
               m1a = a[i];
            end
         endcase
      end

      v3alu_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock (clock),
         .en    (en),
         .func  (req_func),
         .m1a   (m1a),
         .m1b   (m1b),
         .m2a   (b[J]),
         .m2b   (a[K]),
         .a     (a[i]),
         .b     (b[i]),
         .vec   (ln_vec[i]),
         .num   (ln_num[i]),
         .sq    (ln_sq[i]),
         .prod  (ln_prod[i]),
         .ovf   (ln_ovf[i])
      );

      v3alu_div #(
         .NUM_W (NUM_W),
         .DEN_W (WORD_W)
      ) u_div (
         .clock (clock),
         .en    (en),
         .num   ({nmag_ff[i], {FRAC_BITS{1'b0}}}),
         .den   (den_ff),
         .quo   (quo[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_f_ff <= '0;
      end else if (en) begin
         vld_f_ff <= {vld_f_ff[FRONT_LAT-2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff[0] <= ctl_in;
         for (int k = 1; k < FRONT_LAT; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   // merge lanes: dot product and sum of squares
   always_comb begin
      dot_sum   = SAT_W'(ln_prod[0]) + SAT_W'(ln_prod[1]) + SAT_W'(ln_prod[2]);
      dot_sh    = dot_sum >>> FRAC_BITS;
      dot_s     = v3alu_pkg::sat_word(dot_sh);
      magsum_in = ln_sq[0] + ln_sq[1] + ln_sq[2];
      pay4_in.func   = ctl_ff[FRONT_LAT-1].func;
      pay4_in.match  = ctl_ff[FRONT_LAT-1].match;
      pay4_in.s_neg  = ctl_ff[FRONT_LAT-1].s_neg;
      pay4_in.s_zero = ctl_ff[FRONT_LAT-1].s_zero;
      pay4_in.s_mag  = ctl_ff[FRONT_LAT-1].s_mag;
      pay4_in.dz     = 1'b0;
      pay4_in.neg    = '0;
      pay4_in.ovf    = |ln_ovf;
      pay4_in.scal   = '0;
      if (ctl_ff[FRONT_LAT-1].func == v3alu_pkg::FUNC_DOT) begin
         pay4_in.scal = dot_s.word;
         pay4_in.ovf  = dot_s.ovf;
      end
      for (int i = 0; i < LANES; i++) begin
         pay4_in.vec[i] = ln_vec[i];
         pay4_in.num[i] = ln_num[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff  <= 1'b0;
         vld_s_ff <= '0;
         vld5_ff  <= 1'b0;
         vld_d_ff <= '0;
      end else if (en) begin
         vld4_ff  <= vld_f_ff[FRONT_LAT-1];
         vld_s_ff <= {vld_s_ff[SQ_LAT-2:0], vld4_ff};
         vld5_ff  <= vld_s_ff[SQ_LAT-1];
         vld_d_ff <= {vld_d_ff[DIV_LAT-2:0], vld5_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pay4_ff     <= pay4_in;
         magsum_ff   <= magsum_in;
         pay_s_ff[0] <= pay4_ff;
         for (int k = 1; k < SQ_LAT; k++) begin
            pay_s_ff[k] <= pay_s_ff[k-1];
         end
         pay5_ff     <= pay5_in;
         den_ff      <= den_in;
         for (int i = 0; i < LANES; i++) begin
            nmag_ff[i] <= nmag_in[i];
         end
         pay_d_ff[0] <= pay5_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            pay_d_ff[k] <= pay_d_ff[k-1];
         end
      end
   end

   v3alu_sqrt u_sqrt (
      .clock    (clock),
      .en       (en),
      .radicand (magsum_ff),
      .root     (mag)
   );

   // magnitude result, divisor choice and operand signs
   always_comb begin
      pay5_in = pay_s_ff[SQ_LAT-1];
      den_in  = mag;
      case (pay_s_ff[SQ_LAT-1].func) inside
         v3alu_pkg::FUNC_MAG: begin
            pay5_in.scal = mag[ROOT_W-1] ? v3alu_pkg::WORD_MAX : mag;
            pay5_in.ovf  = pay_s_ff[SQ_LAT-1].ovf | mag[ROOT_W-1];
         end
         v3alu_pkg::FUNC_DIV: begin
            pay5_in.dz = pay_s_ff[SQ_LAT-1].s_zero;
            den_in     = pay_s_ff[SQ_LAT-1].s_mag;
         end
         v3alu_pkg::FUNC_CROSS, v3alu_pkg::FUNC_NORM: begin
            pay5_in.dz = (mag == '0);
         end
         default: begin
            den_in = mag;
         end
      endcase
      for (int i = 0; i < LANES; i++) begin
         pay5_in.neg[i] = pay_s_ff[SQ_LAT-1].num[i][WORD_W-1] ^
                          ((pay_s_ff[SQ_LAT-1].func == v3alu_pkg::FUNC_DIV) &&
                           pay_s_ff[SQ_LAT-1].s_neg);
         nmag_in[i]     = pay_s_ff[SQ_LAT-1].num[i][WORD_W-1] ?
                          (~pay_s_ff[SQ_LAT-1].num[i] + 1'b1) :
                          pay_s_ff[SQ_LAT-1].num[i];
      end
   end

   // final compose: signed quotient, saturate, select by opcode
   always_comb begin
      pl_out = pay_d_ff[DIV_LAT-1];
      case (pl_out.func) inside
         v3alu_pkg::FUNC_DIV, v3alu_pkg::FUNC_CROSS, v3alu_pkg::FUNC_NORM: quot_op = 1'b1;
         default: quot_op = 1'b0;
      endcase
      ovf_out = pl_out.ovf;
      for (int i = 0; i < LANES; i++) begin
         qv[i] = SAT_W'(quo[i]);
         if (pl_out.neg[i]) begin
            qv[i] = -qv[i];
         end
         qs[i] = v3alu_pkg::sat_word(qv[i]);
         case (pl_out.func) inside
            v3alu_pkg::FUNC_ADD, v3alu_pkg::FUNC_SUB, v3alu_pkg::FUNC_MUL: begin
               res[i] = pl_out.vec[i];
            end
            v3alu_pkg::FUNC_DIV, v3alu_pkg::FUNC_CROSS, v3alu_pkg::FUNC_NORM: begin
               res[i] = pl_out.dz ? '0 : qs[i].word;
            end
            default: begin
               res[i] = '0;
            end
         endcase
         ovf_out = ovf_out | (quot_op && !pl_out.dz && qs[i].ovf);
      end
      rsp_in = {{(RSP_W-v3alu_pkg::OVF_BIT-1){1'b0}}, ovf_out, pl_out.dz, pl_out.match,
                pl_out.scal, res[2], res[1], res[0]};
   end

   assign push = en && vld_d_ff[DIV_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (rsp_tready) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end
      end else if (!out_vld_ff || rsp_tready) begin
         out_vld_ff <= push;
      end else if (push) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (rsp_tready) begin
            out_ff <= skid_ff;
         end
      end else if (!out_vld_ff || rsp_tready) begin
         out_ff <= rsp_in;
      end else if (push) begin
         skid_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid entry held without an output entry");

   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff && !rsp_tready |=> skid_vld_ff)
      else $error("skid entry dropped while receiver stalled");

   a_match_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[v3alu_pkg::MATCH_BIT] |->
         (rsp_tdata[v3alu_pkg::MATCH_BIT-1:0] == '0) && !rsp_tdata[v3alu_pkg::DZ_BIT] &&
         !rsp_tdata[v3alu_pkg::OVF_BIT])
      else $error("equality result carries other fields");

   a_dz_zero_vec: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[v3alu_pkg::DZ_BIT] |-> (rsp_tdata[LANES*WORD_W-1:0] == '0))
      else $error("zero divisor result has non-zero vector");
`endif

endmodule
